// ===== hdl/aes_cbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package aes_cbc_pkg;

    localparam int RK_ROWS = 15;   // one 128-bit round key per row
    localparam int LAST_STEP = 14;

    typedef struct packed {
        logic         en;
        logic [3:0]   addr;
        logic [127:0] data;
    } t_rk_wr;

    typedef enum logic [2:0] {
        CFG_KEY0   = 3'd0,
        CFG_KEY1   = 3'd1,
        CFG_KEY2   = 3'd2,
        CFG_KEY3   = 3'd3,
        CFG_IV_HI  = 3'd4,
        CFG_IV_LO  = 3'd5,
        CFG_DECRYPT = 3'd6
    } t_cfg_idx;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] DEC_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc = acc ^ x;
            x = xtime(x);
        end
        return acc;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
    endfunction

    // byte j of the state sits at bits 127-8j; byte r+4c is row r, column c
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127-8*(r+4*c) -: 8] = FWD_SBOX[s[127-8*(r+4*((c+r)%4)) -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127-8*(r+4*((c+r)%4)) -: 8] = DEC_SBOX[s[127-8*(r+4*c) -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   m [4];
        logic [7:0]   v;
        m[0] = inv ? 8'h0e : 8'h02;
        m[1] = inv ? 8'h0b : 8'h03;
        m[2] = inv ? 8'h0d : 8'h01;
        m[3] = inv ? 8'h09 : 8'h01;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v = v ^ gmul(s[127-8*(k+4*c) -: 8], m[(k-r+4)%4]);
                t[127-8*(r+4*c) -: 8] = v;
            end
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/aes256_cbc_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake                  Payload
// s        in   i_s_tvalid / o_s_tready    i_s_tdata (128), i_s_tuser (1)
// m        out  o_m_tvalid / i_m_tready    o_m_tdata (128)
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_addr (3), i_cfg_data (64)
//
// An item is taken in IDLE, reads its first round key in START, then runs 15
// round steps through the shared round unit (one AES round per cycle), then DONE.
// After reset or any key write the next item first runs a 60-word key
// expansion (one schedule word per cycle into the round-key RAM).
// Reset is synchronous, active low; the RAM holds no reset.
// A new item is taken while an earlier result still waits on m; a stalled
// result holds the block in DONE until the output register frees.
module aes256_cbc_cipher
    import aes_cbc_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire [127:0]  i_s_tdata,   // [63:0] block_upper, [127:64] block_lower
    input  wire          i_s_tuser,   // [0] first_block
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [127:0] o_m_tdata,   // [63:0] result_upper, [127:64] result_lower
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire [2:0]    i_cfg_addr,
    input  wire [63:0]   i_cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_START, S_ROUND, S_DONE} t_state;

    t_state       r_state;
    logic [255:0] r_key;
    logic [127:0] r_iv;
    logic         r_dec_cfg;
    logic         r_key_dirty;
    logic [127:0] r_chain;     // {upper, lower}
    logic [127:0] r_blk;
    logic [127:0] r_s;
    logic         r_dec;
    logic [3:0]   r_step;
    logic [127:0] r_out;

    logic         s_acc;
    logic         key_wr;
    logic         exp_done;
    t_rk_wr       rk_wr;
    logic [3:0]   rd_addr;
    logic [3:0]   nxt_step;
    logic [127:0] rk;
    logic [127:0] round_out;
    logic [127:0] blk_in;
    logic [127:0] chain_eff;
    logic [127:0] result;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    // any key word write forces a fresh schedule
    assign key_wr      = i_cfg_valid && (i_cfg_addr <= CFG_KEY3);
    assign o_m_tdata   = {r_out[63:0], r_out[127:64]};
    assign blk_in      = {i_s_tdata[63:0], i_s_tdata[127:64]};
    assign chain_eff   = i_s_tuser ? r_iv : r_chain;
    assign result      = r_dec ? (r_s ^ r_chain) : r_s;

    // key row for a step: ascending for encrypt, descending for decrypt
    always_comb begin
        nxt_step = (r_state == S_START) ? 4'd0 :
                   ((r_step == 4'(LAST_STEP)) ? 4'd0 : r_step + 4'd1);
        rd_addr  = r_dec ? (4'(LAST_STEP) - nxt_step) : nxt_step;
    end

    aes_cbc_keyexp u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_acc && r_key_dirty),
        .i_key   (r_key),
        .o_wr    (rk_wr),
        .o_done  (exp_done)
    );

    aes_cbc_ram #(.WIDTH(128), .DEPTH(RK_ROWS)) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (rk_wr.en),
        .i_waddr (rk_wr.addr),
        .i_wdata (rk_wr.data),
        .i_raddr (rd_addr),
        .o_rdata (rk)
    );

    aes_cbc_round u_round (
        .i_state (r_s),
        .i_rk    (rk),
        .i_dec   (r_dec),
        .i_first (r_step == 4'd0),
        .i_last  (r_step == 4'(LAST_STEP)),
        .o_state (round_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key       <= '0;
            r_iv        <= '0;
            r_dec_cfg   <= 1'b0;
            r_key_dirty <= 1'b1;
            r_chain     <= '0;
            r_dec       <= 1'b0;
            r_step      <= '0;
            o_m_tvalid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_KEY0:    r_key[255:192] <= i_cfg_data;
                    CFG_KEY1:    r_key[191:128] <= i_cfg_data;
                    CFG_KEY2:    r_key[127:64]  <= i_cfg_data;
                    CFG_KEY3:    r_key[63:0]    <= i_cfg_data;
                    CFG_IV_HI:   r_iv[127:64] <= i_cfg_data;
                    CFG_IV_LO:   r_iv[63:0]   <= i_cfg_data;
                    CFG_DECRYPT: r_dec_cfg    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (key_wr) r_key_dirty <= 1'b1;
            else if (s_acc) r_key_dirty <= 1'b0;
            // DONE reloads the output register itself
            if (o_m_tvalid && i_m_tready && r_state != S_DONE) o_m_tvalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_chain <= chain_eff;
                        r_blk   <= blk_in;
                        r_dec   <= r_dec_cfg;
                        r_s     <= r_dec_cfg ? blk_in : (blk_in ^ chain_eff);
                        r_state <= r_key_dirty ? S_EXPAND : S_START;
                    end
                end
                S_EXPAND: begin
                    if (exp_done) r_state <= S_START;
                end
                S_START: begin
                    r_step  <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_s    <= round_out;
                    r_step <= nxt_step;
                    if (r_step == 4'(LAST_STEP)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!o_m_tvalid || i_m_tready) begin
                        r_out      <= result;
                        o_m_tvalid <= 1'b1;
                        r_chain    <= r_dec ? r_blk : result;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // the schedule is never rewritten while rounds read it
    a_no_wr_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND || r_state == S_START) |-> !rk_wr.en)
        else $error("round key written during rounds");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("ready after accept");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_DONE))
        else $error("result without finished rounds");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND |-> r_step <= 4'(LAST_STEP))
        else $error("round step out of range");
endmodule
`default_nettype wire

// ===== hdl/aes_cbc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aes_cbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/aes_cbc_keyexp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aes_cbc_keyexp
    import aes_cbc_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire [255:0]  i_key,
    output t_rk_wr       o_wr,
    output logic         o_done
);
    // one schedule word per cycle, 60 words, packed four to a row
    logic         r_busy;
    logic [5:0]   r_idx;
    logic [7:0]   r_rc;
    logic [31:0]  r_win [8];
    logic [95:0]  r_row;
    logic [31:0]  n_word;
    logic [31:0]  t;

    always_comb begin
        t = r_win[7];
        if (r_idx[2:0] == 3'd0) t = sub_word({t[23:0], t[31:24]}) ^ {r_rc, 24'h0};
        else if (r_idx[2:0] == 3'd4) t = sub_word(t);
        if (r_idx < 6'd8) n_word = i_key[255 - 32*r_idx[2:0] -: 32];
        else n_word = r_win[0] ^ t;
    end

    assign o_wr.en   = r_busy && (r_idx[1:0] == 2'd3);
    assign o_wr.addr = r_idx[5:2];
    assign o_wr.data = {r_row, n_word};
    assign o_done    = r_busy && (r_idx == 6'd59);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_rc   <= 8'h01;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_rc   <= 8'h01;
        end else if (r_busy) begin
            r_idx <= r_idx + 6'd1;
            if (r_idx == 6'd59) r_busy <= 1'b0;
            if (r_idx >= 6'd8 && r_idx[2:0] == 3'd0) r_rc <= xtime(r_rc);
        end
        if (r_busy) begin
            for (int j = 0; j < 7; j++) r_win[j] <= r_win[j+1];
            r_win[7] <= n_word;
            r_row    <= {r_row[63:0], n_word};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/aes_cbc_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aes_cbc_round
    import aes_cbc_pkg::*;
(
    input  wire [127:0] i_state,
    input  wire [127:0] i_rk,
    input  wire         i_dec,
    input  wire         i_first,
    input  wire         i_last,
    output logic [127:0] o_state
);
    logic [127:0] ss;
    logic [127:0] iss;

    always_comb begin
        ss  = sub_shift(i_state);
        iss = inv_sub_shift(i_state) ^ i_rk;
        if (i_first)     o_state = i_state ^ i_rk;
        else if (i_dec)  o_state = i_last ? iss : mix(iss, 1'b1);
        else             o_state = i_last ? (ss ^ i_rk) : (mix(ss, 1'b0) ^ i_rk);
    end
endmodule
`default_nettype wire

// ===== tb/sv/tb_aes256_cbc_cipher.sv =====
`timescale 1ns / 1ps
module tb_aes256_cbc_cipher;
    import aes_cbc_pkg::*;

    typedef struct packed {
        logic [63:0] blk_hi;
        logic [63:0] blk_lo;
        logic        first;
    } t_block_in;

    // Clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Block inputs, all known from time zero
    logic         i_s_tvalid = 1'b0;
    logic [127:0] i_s_tdata = '0;
    logic         i_s_tuser = 1'b0;
    logic         i_m_tready = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [63:0]  i_cfg_data = '0;
    wire          o_s_tready;
    wire          o_m_tvalid;
    wire  [127:0] o_m_tdata;
    wire          o_cfg_ready;

    aes256_cbc_cipher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: registers as the block should hold them, plus chaining
    logic [63:0]  key_reg [4];
    logic [63:0]  iv_reg [2];
    logic         decrypt_reg;
    logic [127:0] chain_blk;
    logic [31:0]  sched [60];

    t_block_in    pending_blocks[$];
    logic [127:0] expected_blocks[$];
    int           send_idle_pct;
    int           recv_idle_pct;
    int           n_errors;
    int           n_sent;
    int           n_checked;
    int           quiet_cycles;

    // 60-word AES-256 key schedule from the key registers
    function automatic void expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
            sched[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
        for (int i = 8; i < 60; i++) begin
            t = sched[i-1];
            if (i % 8 == 0) begin
                t = {FWD_SBOX[t[23:16]], FWD_SBOX[t[15:8]], FWD_SBOX[t[7:0]],
                     FWD_SBOX[t[31:24]]} ^ {rc, 24'h0};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end else if (i % 8 == 4) begin
                t = {FWD_SBOX[t[31:24]], FWD_SBOX[t[23:16]], FWD_SBOX[t[15:8]],
                     FWD_SBOX[t[7:0]]};
            end
            sched[i] = sched[i-8] ^ t;
        end
    endfunction

    // state byte j at bits 127-8j; row r, column c is byte r+4c
    function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [127:0] round_step(logic [127:0] s, int op);
        // op 0: sub+shift, 1: inverse sub+shift, 2: mix, 3: inverse mix
        logic [127:0] t;
        logic [7:0]   m [4];
        logic [7:0]   v;
        if (op < 2) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    if (op == 0)
                        t[127-8*(r+4*c) -: 8] = FWD_SBOX[s[127-8*(r+4*((c+r)%4)) -: 8]];
                    else
                        t[127-8*(r+4*((c+r)%4)) -: 8] = DEC_SBOX[s[127-8*(r+4*c) -: 8]];
        end else begin
            m = (op == 3) ? '{8'h0e, 8'h0b, 8'h0d, 8'h09} : '{8'h02, 8'h03, 8'h01, 8'h01};
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) begin
                    v = 8'h00;
                    for (int k = 0; k < 4; k++)
                        v ^= gf_times(s[127-8*(k+4*c) -: 8], m[(k-r+4)%4]);
                    t[127-8*(r+4*c) -: 8] = v;
                end
        end
        return t;
    endfunction

    function automatic logic [127:0] round_key(int rnd);
        return {sched[4*rnd], sched[4*rnd+1], sched[4*rnd+2], sched[4*rnd+3]};
    endfunction

    // One CBC step: returns {result_upper, result_lower} in byte order 0..15
    function automatic logic [127:0] cbc_block(t_block_in b);
        logic [127:0] s;
        logic [127:0] blk;
        if (b.first) chain_blk = {iv_reg[0], iv_reg[1]};
        expand_schedule();
        blk = {b.blk_hi, b.blk_lo};
        if (decrypt_reg) begin
            s = blk ^ round_key(14);
            for (int rnd = 13; rnd > 0; rnd--)
                s = round_step(round_step(s, 1) ^ round_key(rnd), 3);
            s = round_step(s, 1) ^ round_key(0) ^ chain_blk;
            chain_blk = blk;
        end else begin
            s = blk ^ chain_blk ^ round_key(0);
            for (int rnd = 1; rnd < 14; rnd++)
                s = round_step(round_step(s, 0), 2) ^ round_key(rnd);
            s = round_step(s, 0) ^ round_key(14);
            chain_blk = s;
        end
        return s;
    endfunction

    // Driver: next queued block goes out once the last one is taken, unless the sender idles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_blocks.push_back(cbc_block(t_block_in'({i_s_tdata[63:0],
                    i_s_tdata[127:64], i_s_tuser})));
                n_sent <= n_sent + 1;
            end
            if ((!i_s_tvalid || o_s_tready) && pending_blocks.size() > 0
                && $urandom_range(99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {pending_blocks[0].blk_lo, pending_blocks[0].blk_hi};
                i_s_tuser  <= pending_blocks[0].first;
                void'(pending_blocks.pop_front());
            end else if (!i_s_tvalid || o_s_tready) begin
                i_s_tvalid <= 1'b0;
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_blocks.size() == 0) begin
                $error("unexpected result item %h", o_m_tdata);
                n_errors++;
            end else begin
                want = expected_blocks.pop_front();
                if (o_m_tdata[63:0] !== want[127:64]) begin
                    $error("result_upper: expected %h, got %h", want[127:64],
                           o_m_tdata[63:0]);
                    n_errors++;
                end
                if (o_m_tdata[127:64] !== want[63:0]) begin
                    $error("result_lower: expected %h, got %h", want[63:0],
                           o_m_tdata[127:64]);
                    n_errors++;
                end
            end
            n_checked++;
        end
    end

    // Watchdog: key expansion plus a stalled result stays far below this
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: key_reg[idx] = value;
            CFG_IV_HI: iv_reg[0] = value;
            CFG_IV_LO: iv_reg[1] = value;
            CFG_DECRYPT: decrypt_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                                 logic [63:0] k3, logic [63:0] iv_hi,
                                 logic [63:0] iv_lo, logic dec);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_IV_HI, iv_hi);
        write_reg(CFG_IV_LO, iv_lo);
        write_reg(CFG_DECRYPT, {63'd0, dec});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_block(logic [63:0] hi, logic [63:0] lo, logic first);
        pending_blocks.push_back(t_block_in'({hi, lo, first}));
    endtask

    // Every item yields a result, so empty queues mean the block is idle;
    // polled mid-cycle so the driver's edge updates have settled
    task automatic drain();
        while (pending_blocks.size() > 0 || i_s_tvalid || expected_blocks.size() > 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_chains(int n_items, bit dec);
        int left;
        int run;
        left = n_items;
        while (left > 0) begin
            run = $urandom_range(1, 12);
            for (int j = 0; j < run && left > 0; j++, left--)
                queue_block(rand64(), rand64(), j == 0 ? 1'b1 : ($urandom_range(19) == 0));
            drain();
            // random key, IV or mode change between runs; each new run starts a chain
            case ($urandom_range(3))
                0: write_reg(t_cfg_idx'($urandom_range(3)), rand64());
                1: write_reg(CFG_DECRYPT, {63'd0, 1'(dec ^ $urandom_range(1))});
                2: write_reg($urandom_range(1) ? CFG_IV_HI : CFG_IV_LO, rand64());
                default: ;
            endcase
        end
    endtask

    initial begin
        logic [63:0] ka, kb, kc, kd, ia, ib;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        quiet_cycles = 0;
        foreach (key_reg[i]) key_reg[i] = '0;
        iv_reg[0] = '0;
        iv_reg[1] = '0;
        decrypt_reg = 1'b0;
        chain_blk = '0;
        send_idle_pct = 31;
        recv_idle_pct = 70;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no first block yet chains from zero under the reset key
        queue_block('0, '0, 1'b0);
        queue_block('1, '1, 1'b0);
        drain();
        // FIPS-197 AES-256 vector, then extremes and a CBC chain
        load_settings(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                      64'h1011121314151617, 64'h18191a1b1c1d1e1f, '0, '0, 1'b0);
        queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        queue_block('1, '0, 1'b0);
        queue_block('0, '1, 1'b0);
        queue_block(64'h8000000000000001, 64'h0000000180000000, 1'b1);
        drain();
        load_settings('1, '1, '1, '1, '1, '1, 1'b1);
        queue_block('1, '1, 1'b1);
        queue_block('0, '0, 1'b0);
        queue_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        drain();
        // Key change and mode change within a chain
        write_reg(CFG_KEY2, 64'h5555aaaa5555aaaa);
        queue_block(64'haaaa5555aaaa5555, 64'h1, 1'b0);
        drain();
        write_reg(CFG_DECRYPT, 64'd0);
        queue_block(64'h1, 64'haaaa5555aaaa5555, 1'b0);
        queue_block('0, '0, 1'b1);
        drain();

        // Random phases with changing idle patterns and settings
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 70 : 0;
            recv_idle_pct = (ph < 2) ? 70 : (ph < 4) ? 31 : 0;
            ka = rand64(); kb = rand64(); kc = rand64(); kd = rand64();
            ia = rand64(); ib = rand64();
            load_settings(ka, kb, kc, kd, ia, ib, ph[0]);
            random_chains(240, ph[0]);
        end
        drain();

        $display("blocks sent %0d, results checked %0d, encrypt and decrypt chains", n_sent,
                 n_checked);
        $display("with key, IV and mode rewrites under varied backpressure");
        if (n_errors == 0 && expected_blocks.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
